### sv/jfdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick drive package
// Shared types and constants for the joystick frame to motor drive block.
// ----------------------------------------------------------------------------
package jfdm_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_X_LO = 3'd1,
        PH_X_HI = 3'd2,
        PH_Y_LO = 3'd3,
        PH_Y_HI = 3'd4
    } phase_t;

    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
    } frame_t;

    localparam logic CFG_HEADER   = 1'b0;
    localparam logic CFG_DEADBAND = 1'b1;

    localparam logic [7:0] HEADER_RESET   = 8'h11;
    localparam logic [7:0] DEADBAND_RESET = 8'd20;

    localparam logic [9:0] JOY_MAX = 10'd1023;

    // Rounded fixed-point multipliers: 707/1000 over 2^20 and 85/241 over 2^19.
    localparam logic [30:0] MIX_MUL   = 31'd741344;
    localparam int          MIX_SHIFT = 20;
    localparam logic [28:0] MAP_MUL   = 29'd184915;
    localparam int          MAP_SHIFT = 19;

    localparam logic [10:0] MAP_IN  = 11'd723;
    localparam logic [8:0]  MAP_OUT = 9'd255;

endpackage

### sv/jfdm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick frame assembler
// Hunts for the header byte, collects four data bytes and pushes one
// clamped joystick frame per complete frame.
// ----------------------------------------------------------------------------
module jfdm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          header_byte,
    input  logic                byte_valid,
    input  logic [7:0]          byte_data,
    output logic                push,
    output jfdm_pkg::frame_t    push_frame
);

    jfdm_pkg::phase_t phase_reg;
    jfdm_pkg::phase_t phase_next;

    logic [7:0] x_low_reg;
    logic [7:0] x_high_reg;
    logic [7:0] y_low_reg;

    logic [15:0] x_raw;
    logic [15:0] y_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jfdm_pkg::PH_HUNT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && phase_reg == jfdm_pkg::PH_X_LO)
        begin
            x_low_reg <= byte_data;
        end
        if (byte_valid && phase_reg == jfdm_pkg::PH_X_HI)
        begin
            x_high_reg <= byte_data;
        end
        if (byte_valid && phase_reg == jfdm_pkg::PH_Y_LO)
        begin
            y_low_reg <= byte_data;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        push       = 1'b0;
        if (byte_valid)
        begin
            case (phase_reg)
                jfdm_pkg::PH_HUNT:
                begin
                    if (byte_data == header_byte)
                    begin
                        phase_next = jfdm_pkg::PH_X_LO;
                    end
                end
                jfdm_pkg::PH_X_LO: phase_next = jfdm_pkg::PH_X_HI;
                jfdm_pkg::PH_X_HI: phase_next = jfdm_pkg::PH_Y_LO;
                jfdm_pkg::PH_Y_LO: phase_next = jfdm_pkg::PH_Y_HI;
                jfdm_pkg::PH_Y_HI:
                begin
                    phase_next = jfdm_pkg::PH_HUNT;
                    push       = 1'b1;
                end
                default: phase_next = jfdm_pkg::PH_HUNT;
            endcase
        end
    end

    assign x_raw = {x_high_reg, x_low_reg};
    assign y_raw = {byte_data, y_low_reg};

    always_comb
    begin
        push_frame.x = (x_raw[15:10] != 6'd0) ? jfdm_pkg::JOY_MAX : x_raw[9:0];
        push_frame.y = (y_raw[15:10] != 6'd0) ? jfdm_pkg::JOY_MAX : y_raw[9:0];
    end

endmodule

### sv/jfdm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame queue
// Small first-in first-out buffer of joystick frames between the frame
// assembler and the mixing pipeline.
// ----------------------------------------------------------------------------
module jfdm_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jfdm_pkg::frame_t    push_frame,
    output logic                full,
    output logic                pop_valid,
    input  logic                pop_ready,
    output jfdm_pkg::frame_t    pop_frame
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jfdm_pkg::frame_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop_valid && pop_ready;
    assign pop_frame = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

### sv/jfdm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive mixer
// Three-stage pipeline: mix and scale, map to the duty range, then apply
// the deadband into the output register.
// ----------------------------------------------------------------------------
module jfdm_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          deadband,
    input  logic                frame_valid,
    output logic                frame_ready,
    input  jfdm_pkg::frame_t    frame,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          duty_a,
    output logic                forward_a,
    output logic [7:0]          duty_b,
    output logic                forward_b
);

    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        out_valid_reg;
    logic        s1_adv;
    logic        s2_adv;
    logic        out_adv;

    logic signed [11:0] sum_a;
    logic signed [11:0] sum_b;
    logic [10:0]        mag_a;
    logic [10:0]        mag_b;

    logic        s1_neg_a_reg;
    logic        s1_neg_b_reg;
    logic [30:0] s1_prod_a_reg;
    logic [30:0] s1_prod_b_reg;

    logic [9:0]  mix_a;
    logic [9:0]  mix_b;
    logic [10:0] map_in_a;
    logic [10:0] map_in_b;

    logic [28:0] s2_prod_a_reg;
    logic [28:0] s2_prod_b_reg;

    logic [8:0]  q_a;
    logic [8:0]  q_b;
    logic [7:0]  spd_a;
    logic [7:0]  spd_b;
    logic        dead_a;
    logic        dead_b;

    logic [7:0]  duty_a_reg;
    logic [7:0]  duty_b_reg;
    logic        forward_a_reg;
    logic        forward_b_reg;

    assign out_adv     = !out_valid_reg || out_ready;
    assign s2_adv      = !s2_valid_reg || out_adv;
    assign s1_adv      = !s1_valid_reg || s2_adv;
    assign frame_ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= frame_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // a + b reduces to x - y, and b - a to 1024 - x - y.
    always_comb
    begin
        sum_a = $signed({2'b00, frame.x}) - $signed({2'b00, frame.y});
        sum_b = 12'sd1024 - $signed({2'b00, frame.x}) - $signed({2'b00, frame.y});
        mag_a = sum_a[11] ? 11'(-sum_a) : sum_a[10:0];
        mag_b = sum_b[11] ? 11'(-sum_b) : sum_b[10:0];
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_neg_a_reg  <= sum_a[11];
            s1_neg_b_reg  <= sum_b[11];
            s1_prod_a_reg <= 31'(mag_a) * jfdm_pkg::MIX_MUL;
            s1_prod_b_reg <= 31'(mag_b) * jfdm_pkg::MIX_MUL;
        end
    end

    always_comb
    begin
        mix_a    = 10'(s1_prod_a_reg >> jfdm_pkg::MIX_SHIFT);
        mix_b    = 10'(s1_prod_b_reg >> jfdm_pkg::MIX_SHIFT);
        map_in_a = s1_neg_a_reg ? jfdm_pkg::MAP_IN - 11'(mix_a) : jfdm_pkg::MAP_IN + 11'(mix_a);
        map_in_b = s1_neg_b_reg ? jfdm_pkg::MAP_IN - 11'(mix_b) : jfdm_pkg::MAP_IN + 11'(mix_b);
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_prod_a_reg <= 29'(map_in_a) * jfdm_pkg::MAP_MUL;
            s2_prod_b_reg <= 29'(map_in_b) * jfdm_pkg::MAP_MUL;
        end
    end

    always_comb
    begin
        q_a    = 9'(s2_prod_a_reg >> jfdm_pkg::MAP_SHIFT);
        q_b    = 9'(s2_prod_b_reg >> jfdm_pkg::MAP_SHIFT);
        spd_a  = (q_a >= jfdm_pkg::MAP_OUT) ? 8'(q_a - jfdm_pkg::MAP_OUT)
                                            : 8'(jfdm_pkg::MAP_OUT - q_a);
        spd_b  = (q_b >= jfdm_pkg::MAP_OUT) ? 8'(q_b - jfdm_pkg::MAP_OUT)
                                            : 8'(jfdm_pkg::MAP_OUT - q_b);
        dead_a = (spd_a < deadband);
        dead_b = (spd_b < deadband);
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            duty_a_reg    <= dead_a ? 8'd0 : spd_a;
            duty_b_reg    <= dead_b ? 8'd0 : spd_b;
            forward_a_reg <= (q_a > jfdm_pkg::MAP_OUT) && !dead_a;
            forward_b_reg <= (q_b > jfdm_pkg::MAP_OUT) && !dead_b;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty_a    = duty_a_reg;
    assign duty_b    = duty_b_reg;
    assign forward_a = forward_a_reg;
    assign forward_b = forward_b_reg;

endmodule

### sv/joystick_frame_to_dual_motor_drive_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick frame to dual motor drive
// Receives serial bytes, assembles joystick frames behind a header byte and
// mixes them into duty and direction for two motors.
//
// The input channel takes one received byte per item on in_valid/in_ready.
// A frame is the header byte followed by x low, x high, y low and y high.
// The output channel gives one item per complete frame on out_valid/out_ready:
// duty and forward flag for each motor. Bytes that do not end a frame give
// no output item.
// One byte is accepted every cycle while in_ready is high. The result of a
// frame passes through the frame queue and then the three pipeline stages
// of the mixer before it appears on the output channel.
// When the receiver stalls, the mixer pipeline and the frame queue fill up;
// in_ready then drops until a result is taken.
// Reset empties the pipeline and the queue, restarts the header hunt and
// loads the header byte 0x11 and deadband 20. cfg_write with cfg_index
// selects which register takes cfg_data.
// ----------------------------------------------------------------------------
module joystick_frame_to_dual_motor_drive_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  duty_a,
    output logic        forward_a,
    output logic [7:0]  duty_b,
    output logic        forward_b
);

    logic [7:0] header_reg;
    logic [7:0] deadband_reg;

    logic             queue_full;
    logic             push;
    jfdm_pkg::frame_t push_frame;
    logic             pop_valid;
    logic             pop_ready;
    jfdm_pkg::frame_t pop_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= jfdm_pkg::HEADER_RESET;
            deadband_reg <= jfdm_pkg::DEADBAND_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                jfdm_pkg::CFG_HEADER:   header_reg   <= cfg_data;
                jfdm_pkg::CFG_DEADBAND: deadband_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = !queue_full;

    jfdm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_byte (header_reg),
        .byte_valid  (in_valid && in_ready),
        .byte_data   (rx_byte),
        .push        (push),
        .push_frame  (push_frame)
    );

    jfdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    jfdm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .deadband    (deadband_reg),
        .frame_valid (pop_valid),
        .frame_ready (pop_ready),
        .frame       (pop_frame),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .duty_a      (duty_a),
        .forward_a   (forward_a),
        .duty_b      (duty_b),
        .forward_b   (forward_b)
    );

endmodule
